// ----- design/rtts_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the round-trip time statistics block
package rtts_pkg;

	localparam int SAMPLE_DEPTH_DEF = 128;
	localparam int RTT_W = 24;
	localparam int CNT_W = 32;
	localparam int SUM_W = 56;
	localparam int LOSS_W = 14;
	localparam int ACC_W = 64;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [13:0] LOSS_SCALE = 14'd10000;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_LOSS   = 2'd1,
		FUNC_CLEAR  = 2'd2,
		FUNC_REPORT = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_AVG,
		ST_LOSS,
		ST_SCAN,
		ST_SQ,
		ST_VAR,
		ST_SQRT,
		ST_DONE
	} state_t;

	// divider control between sequencer and divider unit
	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ----- design/rtts_div.sv -----
`timescale 1ns / 1ps
// restoring radix-2 divider, one quotient bit per cycle
module rtts_div
	import rtts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CW = $clog2(ACC_W + 1);

	logic [ACC_W-1:0] quo_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W-1:0] den_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   trial;
	logic             ge;

	always_comb begin
		trial = {rem_q[CNT_W-1:0], quo_q[ACC_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[ACC_W-2:0], ge};
			rem_q <= ge ? trial - {1'b0, den_q} : trial;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- design/rtts_sqrt.sv -----
`timescale 1ns / 1ps
// bitwise integer square root, two radicand bits per cycle
module rtts_sqrt
	import rtts_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] radicand,
	output logic             done,
	output logic [RTT_W-1:0] root
);

	localparam int RW = ACC_W / 2;
	localparam int CW = $clog2(RW + 1);

	logic [ACC_W-1:0] v_q;
	logic [ACC_W-1:0] res_q;
	logic [ACC_W-1:0] bit_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [ACC_W-1:0] tst;

	assign tst = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// leading zero skip is unnecessary: steps with bit above v fail the compare
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= ACC_W'(1) << (ACC_W - 2);
		end else if (busy_q) begin
			if (v_q >= tst) begin
				v_q   <= v_q - tst;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[RTT_W-1:0];

endmodule

// ----- design/round_trip_time_statistics.sv -----
`timescale 1ns / 1ps
// round-trip time statistics: running min/max/sum, sample ring, report engine
//
// one command channel: func and rtt_us are taken when start is high and busy
// is low. add sample, record loss and clear complete at the accepting edge and
// never raise busy, so they can follow each other with no gap.
// a report raises busy until its result is shown: min_rtt .. loss_hundredths
// are valid for exactly one cycle while valid is high; the receiver cannot
// stall, so the result must be captured in that cycle.
// with N >= 2 stored samples a report runs, in order: the average and
// loss-rate divides, a scan of the ring memory (one read a cycle, then a
// square and an accumulate), a drain of that pipeline, the variance divide,
// the square root unit and a final state to present; valid goes high in the
// same cycle that busy goes low.
// with fewer than two samples the scan, variance divide and square root are
// skipped; a divide whose divisor is zero is not started and is not waited for.
// reset returns all counters and extremes to their cleared values; the ring
// memory is left as is and needs no sweep.
module round_trip_time_statistics
	import rtts_pkg::*;
#(
	parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          func,
	input  logic [RTT_W-1:0]    rtt_us,
	output logic                valid,
	output logic [RTT_W-1:0]    min_rtt,
	output logic [RTT_W-1:0]    max_rtt,
	output logic [RTT_W-1:0]    avg_rtt,
	output logic [RTT_W-1:0]    jitter,
	output logic [CNT_W-1:0]    sent_total,
	output logic [CNT_W-1:0]    received_total,
	output logic [CNT_W-1:0]    lost_total,
	output logic [LOSS_W-1:0]   loss_hundredths
);

	localparam int AW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int NW = $clog2(SAMPLE_DEPTH + 1);

	logic [RTT_W-1:0] ring [SAMPLE_DEPTH];
	logic [RTT_W-1:0] rd_s1;

	state_t state_q, state_d;
	logic [NW-1:0]    stored_q;
	logic [AW-1:0]    wptr_q;
	logic [CNT_W-1:0] sent_q, lost_q;
	logic [RTT_W-1:0] min_q, max_q;
	logic [SUM_W-1:0] sum_q;
	logic [RTT_W-1:0] avg_q, jit_q;
	logic [LOSS_W-1:0] lossr_q;
	logic [ACC_W-1:0] acc_q;
	logic [NW-1:0]    idx_q;
	logic             rdv_s1;
	logic [RTT_W-1:0] dif_s2;
	logic             dv_s2;
	logic [2*RTT_W-1:0] sq_s3;
	logic             sqv_s3;
	logic             div_go_q, sqrt_go_q, valid_q;

	div_req_t dreq;
	div_rsp_t drsp;
	logic sq_done;
	logic [RTT_W-1:0] sq_root;
	logic [CNT_W-1:0] recv;
	logic take;
	logic add_ok;

	assign recv   = sent_q - lost_q;
	assign take   = start && !busy;
	assign add_ok = sent_q != CNT_MAX;

	rtts_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	rtts_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .start(sqrt_go_q), .radicand(acc_q),
		.done(sq_done), .root(sq_root));

	// ring memory: single write port, one registered read
	always_ff @(posedge clk) begin
		if (take && func_t'(func) == FUNC_ADD && add_ok)
			ring[wptr_q] <= rtt_us;
		rd_s1 <= ring[idx_q[AW-1:0]];
	end

	always_comb begin
		dreq.start    = div_go_q;
		dreq.dividend = '0;
		dreq.divisor  = '0;
		unique case (state_q)
			ST_AVG: begin
				dreq.dividend = ACC_W'(sum_q);
				dreq.divisor  = recv;
			end
			ST_LOSS: begin
				dreq.dividend = ACC_W'(lost_q) * ACC_W'(LOSS_SCALE);
				dreq.divisor  = sent_q;
			end
			ST_VAR: begin
				dreq.dividend = acc_q;
				dreq.divisor  = CNT_W'(stored_q);
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:
				if (take && func_t'(func) == FUNC_REPORT) state_d = ST_AVG;
			ST_CLEAR: state_d = ST_IDLE;
			ST_AVG:  if (drsp.done || recv == '0) state_d = ST_LOSS;
			ST_LOSS: if (drsp.done || sent_q == '0)
				state_d = (stored_q < NW'(2)) ? ST_DONE : ST_SCAN;
			ST_SCAN: if (idx_q == stored_q) state_d = ST_SQ;
			ST_SQ:   if (!rdv_s1 && !dv_s2 && !sqv_s3) state_d = ST_VAR;
			ST_VAR:  if (drsp.done) state_d = ST_SQRT;
			ST_SQRT: if (sq_done) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy = state_q != ST_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			stored_q  <= '0;
			wptr_q    <= '0;
			sent_q    <= '0;
			lost_q    <= '0;
			min_q     <= '1;
			max_q     <= '0;
			sum_q     <= '0;
			div_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			valid_q   <= 1'b0;
			rdv_s1    <= 1'b0;
			dv_s2     <= 1'b0;
			sqv_s3    <= 1'b0;
			idx_q     <= '0;
		end else begin
			state_q   <= state_d;
			div_go_q  <= 1'b0;
			sqrt_go_q <= 1'b0;
			valid_q   <= state_q == ST_DONE;
			rdv_s1    <= state_q == ST_SCAN && idx_q != stored_q;
			dv_s2     <= rdv_s1;
			sqv_s3    <= dv_s2;
			if (take) begin
				unique case (func_t'(func))
					FUNC_ADD: if (add_ok) begin
						wptr_q <= (wptr_q == AW'(SAMPLE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
						if (stored_q != NW'(SAMPLE_DEPTH)) stored_q <= stored_q + 1'b1;
						sent_q <= sent_q + 1'b1;
						sum_q  <= sum_q + SUM_W'(rtt_us);
						if (rtt_us < min_q) min_q <= rtt_us;
						if (rtt_us > max_q) max_q <= rtt_us;
					end
					FUNC_LOSS: if (add_ok) begin
						sent_q <= sent_q + 1'b1;
						lost_q <= lost_q + 1'b1;
					end
					FUNC_CLEAR: begin
						stored_q <= '0;
						wptr_q   <= '0;
						sent_q   <= '0;
						lost_q   <= '0;
						min_q    <= '1;
						max_q    <= '0;
						sum_q    <= '0;
					end
					FUNC_REPORT: begin
						div_go_q <= recv != '0;
						idx_q    <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_AVG && (drsp.done || recv == '0))
				div_go_q <= sent_q != '0;
			if (state_q == ST_LOSS && (drsp.done || sent_q == '0))
				idx_q <= '0;
			if (state_q == ST_SCAN && idx_q != stored_q)
				idx_q <= idx_q + 1'b1;
			if (state_q == ST_SQ && state_d == ST_VAR)
				div_go_q <= 1'b1;
			if (state_q == ST_VAR && drsp.done)
				sqrt_go_q <= 1'b1;
		end
	end

	// report datapath
	always_ff @(posedge clk) begin
		if (take && func_t'(func) == FUNC_REPORT) begin
			avg_q   <= '0;
			lossr_q <= '0;
			jit_q   <= '0;
			acc_q   <= '0;
		end
		if (state_q == ST_AVG && drsp.done && stored_q != '0)
			avg_q <= drsp.quotient[RTT_W-1:0];
		if (state_q == ST_LOSS && drsp.done)
			lossr_q <= drsp.quotient[LOSS_W-1:0];
		dif_s2 <= (rd_s1 >= avg_q) ? rd_s1 - avg_q : avg_q - rd_s1;
		sq_s3  <= dif_s2 * dif_s2;
		if (sqv_s3) acc_q <= acc_q + ACC_W'(sq_s3);
		if (state_q == ST_VAR && drsp.done) acc_q <= drsp.quotient;
		if (sq_done) jit_q <= sq_root;
	end

	// average and loss waits skip the divider when it is not started
	assign valid           = valid_q;
	assign min_rtt         = (recv == '0) ? '0 : min_q;
	assign max_rtt         = max_q;
	assign avg_rtt         = avg_q;
	assign jitter          = jit_q;
	assign sent_total      = sent_q;
	assign received_total  = recv;
	assign lost_total      = lost_q;
	assign loss_hundredths = lossr_q;

endmodule

// ----- design/rtts_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the statistics block, bound to the top level
module rtts_checker
	import rtts_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             busy,
	input logic             valid,
	input logic [CNT_W-1:0] sent_total,
	input logic [CNT_W-1:0] received_total,
	input logic [CNT_W-1:0] lost_total,
	input logic [LOSS_W-1:0] loss_hundredths
);

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy) && !busy) else $error("result outside report");
	a_valid_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid) else $error("result held two cycles");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> sent_total == received_total + lost_total) else $error("count mismatch");
	a_loss_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> loss_hundredths <= LOSS_SCALE) else $error("loss rate range");

endmodule

bind round_trip_time_statistics rtts_checker u_rtts_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .valid(valid),
	.sent_total(sent_total), .received_total(received_total),
	.lost_total(lost_total), .loss_hundredths(loss_hundredths)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for the round-trip time statistics block: queued commands, predicted reports
module testbench;
	import rtts_pkg::*;

	localparam int DEPTH = SAMPLE_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		func_t            op;
		logic [RTT_W-1:0] rtt;
	} command_t;

	typedef struct {
		logic [RTT_W-1:0]  min_v;
		logic [RTT_W-1:0]  max_v;
		logic [RTT_W-1:0]  avg_v;
		logic [RTT_W-1:0]  jit_v;
		logic [CNT_W-1:0]  sent_v;
		logic [CNT_W-1:0]  recv_v;
		logic [CNT_W-1:0]  lost_v;
		logic [LOSS_W-1:0] loss_v;
	} report_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic [1:0] func = FUNC_ADD;
	logic [RTT_W-1:0] rtt_us = '0;
	logic busy, valid;
	logic [RTT_W-1:0] min_rtt, max_rtt, avg_rtt, jitter;
	logic [CNT_W-1:0] sent_total, received_total, lost_total;
	logic [LOSS_W-1:0] loss_hundredths;

	round_trip_time_statistics uut (.*);

	command_t pending_cmds[$];
	report_t  expected_reports[$];
	int errors = 0;
	int reports_seen = 0;
	int idle_cycles = 0;
	int gap_left = 0;
	bit stim_done = 0;
	bit timed_out = 0;

	// predictor state
	logic [RTT_W-1:0] ring[DEPTH];
	int unsigned      n_stored, wr_ptr;
	logic [CNT_W-1:0] sent_cnt, lost_cnt;
	logic [RTT_W-1:0] run_min, run_max;
	logic [SUM_W-1:0] run_sum;

	initial forever #4 clk = ~clk;

	function automatic void clear_stats();
		n_stored = 0;
		wr_ptr = 0;
		sent_cnt = 0;
		lost_cnt = 0;
		run_min = '1;
		run_max = 0;
		run_sum = 0;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void predict_stats(command_t c);
		report_t r;
		logic [CNT_W-1:0] recv;
		logic [63:0] avg, acc, d;
		case (c.op)
			FUNC_ADD: begin
				if (sent_cnt != CNT_MAX) begin
					ring[wr_ptr] = c.rtt;
					wr_ptr = (wr_ptr + 1) % DEPTH;
					if (n_stored < DEPTH) n_stored++;
					sent_cnt++;
					run_sum += c.rtt;
					if (c.rtt < run_min) run_min = c.rtt;
					if (c.rtt > run_max) run_max = c.rtt;
				end
			end
			FUNC_LOSS: begin
				if (sent_cnt != CNT_MAX) begin
					sent_cnt++;
					lost_cnt++;
				end
			end
			FUNC_CLEAR: clear_stats();
			default: begin
				recv = sent_cnt - lost_cnt;
				avg = (n_stored == 0 || recv == 0) ? 64'd0 : 64'(run_sum) / recv;
				avg = avg & 64'hFFFFFF;
				acc = 0;
				if (n_stored >= 2) begin
					for (int i = 0; i < n_stored; i++) begin
						d = (ring[i] >= avg) ? ring[i] - avg : avg - ring[i];
						acc += d * d;
					end
					acc /= n_stored;
				end
				r.min_v = (recv == 0) ? '0 : run_min;
				r.max_v = run_max;
				r.avg_v = avg[RTT_W-1:0];
				r.jit_v = (n_stored >= 2) ? RTT_W'(int_sqrt(acc)) : '0;
				r.sent_v = sent_cnt;
				r.recv_v = recv;
				r.lost_v = lost_cnt;
				r.loss_v = (sent_cnt == 0) ? '0 :
					LOSS_W'((64'(lost_cnt) * 10000) / sent_cnt);
				expected_reports.push_back(r);
			end
		endcase
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [RTT_W-1:0] pick_rtt();
		case ($urandom_range(0, 5))
			0: return RTT_W'($urandom);
			1: return RTT_W'(24'hFFFFFF - $urandom_range(0, 3));
			2: return RTT_W'($urandom_range(0, 3));
			default: return RTT_W'($urandom_range(1000, 300000));
		endcase
	endfunction

	// driver: one transaction per acceptance, inputs move on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				// accepted at the preceding rising edge; handled by the acceptance block
			end
		end
	end

	bit accepted_now;
	always @(posedge clk) begin
		accepted_now <= arst_n && start && !busy;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || accepted_now) begin
				if (accepted_now) begin
					predict_stats(pending_cmds.pop_front());
					gap_left = pick_gap();
				end
				if (gap_left > 0 || pending_cmds.size() == 0) begin
					if (gap_left > 0) gap_left--;
					start <= 0;
				end else begin
					start <= 1;
					func <= pending_cmds[0].op;
					rtt_us <= pending_cmds[0].rtt;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (valid) begin
				reports_seen++;
				if (expected_reports.size() == 0) begin
					errors++;
					$display("%0t: report with none expected", $time);
				end else begin
					report_t e;
					e = expected_reports.pop_front();
					if ({min_rtt, max_rtt, avg_rtt, jitter, sent_total, received_total,
						lost_total, loss_hundredths} !== {e.min_v, e.max_v, e.avg_v,
						e.jit_v, e.sent_v, e.recv_v, e.lost_v, e.loss_v}) begin
						errors++;
						$display("%0t: expected min %0d max %0d avg %0d jit %0d sent %0d recv %0d lost %0d loss %0d",
							$time, e.min_v, e.max_v, e.avg_v, e.jit_v, e.sent_v, e.recv_v,
							e.lost_v, e.loss_v);
						$display("%0t: actual   min %0d max %0d avg %0d jit %0d sent %0d recv %0d lost %0d loss %0d",
							$time, min_rtt, max_rtt, avg_rtt, jitter, sent_total,
							received_total, lost_total, loss_hundredths);
					end
				end
			end
			if ((start && !busy) || valid) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_cmd(func_t op, logic [RTT_W-1:0] rtt);
		command_t c;
		c.op = op;
		c.rtt = rtt;
		pending_cmds.push_back(c);
	endtask

	initial begin
		int n;
		clear_stats();
		for (int i = 0; i < DEPTH; i++) ring[i] = 0;
		// directed: empty report, single sample, extremes, loss only, clear
		push_cmd(FUNC_REPORT, 24'd0);
		push_cmd(FUNC_ADD, '1);
		push_cmd(FUNC_REPORT, 24'd0);
		push_cmd(FUNC_ADD, 24'd0);
		push_cmd(FUNC_ADD, 24'hAAAAAA);
		push_cmd(FUNC_ADD, 24'h555555);
		push_cmd(FUNC_REPORT, '1);
		push_cmd(FUNC_LOSS, 24'h123456);
		push_cmd(FUNC_REPORT, 24'd0);
		push_cmd(FUNC_CLEAR, '1);
		push_cmd(FUNC_LOSS, 24'd0);
		push_cmd(FUNC_LOSS, 24'd0);
		push_cmd(FUNC_REPORT, 24'd0);
		push_cmd(FUNC_ADD, 24'd7);
		push_cmd(FUNC_ADD, 24'd7);
		push_cmd(FUNC_REPORT, 24'd0);
		push_cmd(FUNC_CLEAR, 24'd0);
		// random: samples, losses, occasional clears and reports, in random order
		n = 0;
		while (n < 1230) begin
			int p;
			p = $urandom_range(0, 99);
			if (p < 70) push_cmd(FUNC_ADD, pick_rtt());
			else if (p < 82) push_cmd(FUNC_LOSS, RTT_W'($urandom));
			else if (p < 84) push_cmd(FUNC_CLEAR, RTT_W'($urandom));
			else push_cmd(FUNC_REPORT, RTT_W'($urandom));
			n++;
		end
		push_cmd(FUNC_REPORT, 24'd0);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		wait (pending_cmds.size() == 0);
		wait (expected_reports.size() == 0);
		repeat (600) @(posedge clk);
		stim_done = 1;
	end

	initial begin
		@(posedge arst_n);
		while (!stim_done && !timed_out) begin
			@(posedge clk);
			if (idle_cycles > WATCHDOG_LIMIT) timed_out = 1;
		end
		if (timed_out) begin
			$display("Verification failed");
			$finish;
		end else begin
			$display("ran sample, loss, clear and report commands with random gaps; %0d reports checked",
				reports_seen);
			if (errors == 0 && expected_reports.size() == 0)
				$display("Verification passed");
			else
				$display("Verification failed");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
design/rtts_pkg.sv
design/rtts_div.sv
design/rtts_sqrt.sv
design/round_trip_time_statistics.sv
design/rtts_checker.sv
dv/testbench.sv
